>>> design/assert_macros.svh
// Assertion macros shared by the accelerometer magnitude design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AMG_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define AMG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define AMG_ASSERT(lbl, clk, rst_n, prop, msg)
`define AMG_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> design/amg_pkg.sv
// Types and constants of the accelerometer magnitude pipeline
`timescale 1ns / 1ps
package amg_pkg;
	localparam int AXIS_W = 14;
	localparam int MG_W = 12;
	localparam int PROD_W = 21;
	localparam int QUO_W = 11;
	localparam int SQ_W = 22;
	localparam int SUM_W = 24;
	localparam int ROOT_W = 23;
	localparam logic [7:0] MG_NUM = 8'd244;
	localparam logic [21:0] MG_RECIP = 22'd2147484;
	localparam int MG_SHIFT = 31;
	localparam int DIV_BITS = 4;
	localparam int DIV_STAGES = SUM_W / DIV_BITS;
	localparam int STEP_LAT = DIV_STAGES + 1;

	typedef struct packed {
		logic [SUM_W-1:0] s;
		logic [SUM_W-1:0] m;
	} root_t;

	typedef struct packed {
		logic [SUM_W-1:0] rem;
		logic [SUM_W-1:0] quo;
	} div_t;

	typedef struct packed {
		logic signed [MG_W-1:0] x;
		logic signed [MG_W-1:0] y;
		logic signed [MG_W-1:0] z;
	} axes_t;
endpackage

>>> design/amg_axis.sv
// One axis: rebuild raw bytes and scale to milli-g in two stages
`timescale 1ns / 1ps
module amg_axis (
	input  logic                              clk,
	input  logic                              en,
	input  logic                              present,
	input  logic [7:0]                        lo,
	input  logic [7:0]                        hi,
	output logic signed [amg_pkg::MG_W-1:0]   mg
);
	logic [15:0] word;
	logic signed [amg_pkg::AXIS_W-1:0] v;
	logic [amg_pkg::AXIS_W-1:0] mag_v;
	logic [amg_pkg::PROD_W-1:0] prod_s1;
	logic neg_s1;
	logic [42:0] scaled;
	logic [amg_pkg::QUO_W-1:0] quo;

	always_comb begin
		word = {hi, lo};
		v = present ? $signed(word[15:2]) : '0;
		mag_v = v[amg_pkg::AXIS_W-1] ? amg_pkg::AXIS_W'(-v) : amg_pkg::AXIS_W'(v);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= amg_pkg::PROD_W'(mag_v) * amg_pkg::PROD_W'(amg_pkg::MG_NUM);
			neg_s1 <= v[amg_pkg::AXIS_W-1];
		end
	end

	always_comb begin
		scaled = 43'(prod_s1) * 43'(amg_pkg::MG_RECIP);
		quo = scaled[amg_pkg::MG_SHIFT+amg_pkg::QUO_W-1:amg_pkg::MG_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mg <= neg_s1 ? amg_pkg::MG_W'(-{1'b0, quo}) : {1'b0, quo};
		end
	end
endmodule

>>> design/amg_newton.sv
// One Newton step: pipelined restoring divide s/m, then average with m
`timescale 1ns / 1ps
module amg_newton (
	input  logic                  clk,
	input  logic                  en,
	input  amg_pkg::root_t        din,
	output amg_pkg::root_t        dout
);
	localparam int N = amg_pkg::DIV_STAGES;
	localparam int W = amg_pkg::SUM_W;

	logic [W-1:0] s_s [0:N];
	logic [W-1:0] m_s [0:N];
	amg_pkg::div_t d_s [0:N];
	logic [W:0] avg;

	function automatic amg_pkg::div_t div_step(input amg_pkg::div_t d, input logic [W-1:0] m,
			input logic [amg_pkg::DIV_BITS-1:0] bits);
		amg_pkg::div_t r;
		logic [W:0] t;
		r = d;
		for (int i = amg_pkg::DIV_BITS - 1; i >= 0; i--) begin
			t = {r.rem, bits[i]};
			if (t >= {1'b0, m}) begin
				t = t - {1'b0, m};
				r.quo = {r.quo[W-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[W-2:0], 1'b0};
			end
			r.rem = t[W-1:0];
		end
		return r;
	endfunction

	assign s_s[0] = din.s;
	assign m_s[0] = din.m;
	assign d_s[0] = '0;

	for (genvar j = 0; j < N; j++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				s_s[j+1] <= s_s[j];
				m_s[j+1] <= m_s[j];
				d_s[j+1] <= div_step(d_s[j], m_s[j],
					s_s[j][W-1-j*amg_pkg::DIV_BITS -: amg_pkg::DIV_BITS]);
			end
		end
	end

	assign avg = {1'b0, m_s[N]} + {1'b0, d_s[N].quo};

	always_ff @(posedge clk) begin
		if (en) begin
			dout.s <= s_s[N];
			dout.m <= (m_s[N] == '0) ? '0 : avg[W:1];
		end
	end
endmodule

>>> design/accel_magnitude_mg.sv
// Top level of the accelerometer magnitude pipeline
`timescale 1ns / 1ps
// Turns six raw accelerometer bytes into three milli-g axes and the magnitude,
// the integer root of the sum of squares by NEWTON_STEPS Newton steps. One
// word enters per cycle unless the pipeline holds. Its registers are scaling,
// square, sum, each Newton step's divider stages and average, and output. Each
// Newton step is a 24-bit divider retiring 4 quotient bits per stage. The
// whole pipeline holds while the output word is stalled.
`include "assert_macros.svh"
module accel_magnitude_mg #(
	parameter int NEWTON_STEPS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_wdata,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [7:0]                             x_low_byte,
	input  logic [7:0]                             x_high_byte,
	input  logic [7:0]                             y_low_byte,
	input  logic [7:0]                             y_high_byte,
	input  logic [7:0]                             z_low_byte,
	input  logic [7:0]                             z_high_byte,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [amg_pkg::MG_W-1:0]        x_milli_g,
	output logic signed [amg_pkg::MG_W-1:0]        y_milli_g,
	output logic signed [amg_pkg::MG_W-1:0]        z_milli_g,
	output logic [amg_pkg::ROOT_W-1:0]             magnitude_milli_g
);
	localparam int DL = 2 + NEWTON_STEPS * amg_pkg::STEP_LAT;

	logic en;
	logic sensor_present_q;
	logic vld_s1, vld_s2;
	amg_pkg::axes_t ax_s2;
	logic [amg_pkg::SQ_W-1:0] sqx_s3, sqy_s3, sqz_s3;
	logic [amg_pkg::SUM_W-1:0] sum;
	logic signed [23:0] px, py, pz;
	logic vld_dl [0:DL-1];
	amg_pkg::axes_t ax_dl [0:DL-1];
	amg_pkg::root_t root [0:NEWTON_STEPS];

	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_present_q <= 1'b0;
		end else if (cfg_we) begin
			sensor_present_q <= cfg_wdata;
		end
	end

	amg_axis u_x (.clk(clk), .en(en), .present(sensor_present_q),
		.lo(x_low_byte), .hi(x_high_byte), .mg(ax_s2.x));
	amg_axis u_y (.clk(clk), .en(en), .present(sensor_present_q),
		.lo(y_low_byte), .hi(y_high_byte), .mg(ax_s2.y));
	amg_axis u_z (.clk(clk), .en(en), .present(sensor_present_q),
		.lo(z_low_byte), .hi(z_high_byte), .mg(ax_s2.z));

	always_comb begin
		px = ax_s2.x * ax_s2.x;
		py = ax_s2.y * ax_s2.y;
		pz = ax_s2.z * ax_s2.z;
		sum = amg_pkg::SUM_W'(sqx_s3) + amg_pkg::SUM_W'(sqy_s3) + amg_pkg::SUM_W'(sqz_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s3 <= px[amg_pkg::SQ_W-1:0];
			sqy_s3 <= py[amg_pkg::SQ_W-1:0];
			sqz_s3 <= pz[amg_pkg::SQ_W-1:0];
			root[0].s <= sum;
			root[0].m <= (sum > amg_pkg::SUM_W'(1)) ? (sum >> 1) : amg_pkg::SUM_W'(1);
		end
	end

	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
		amg_newton u_step (.clk(clk), .en(en), .din(root[k]), .dout(root[k+1]));
	end

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int i = 0; i < DL; i++) begin
				vld_dl[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_dl[0] <= vld_s2;
			for (int i = 1; i < DL; i++) begin
				vld_dl[i] <= vld_dl[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_dl[0] <= ax_s2;
			for (int i = 1; i < DL; i++) begin
				ax_dl[i] <= ax_dl[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_dl[DL-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_milli_g <= ax_dl[DL-1].x;
			y_milli_g <= ax_dl[DL-1].y;
			z_milli_g <= ax_dl[DL-1].z;
			magnitude_milli_g <= root[NEWTON_STEPS].m[amg_pkg::ROOT_W-1:0];
		end
	end

	`AMG_ASSERT(a_stall_only_when_full, clk, arst_n, !in_stall || out_valid, "input stalled with empty output")
	`AMG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "stalled output word dropped")
	`AMG_ASSERT(a_zero_root, clk, arst_n, !(out_valid && x_milli_g == '0 && y_milli_g == '0 && z_milli_g == '0) || magnitude_milli_g == '0, "nonzero root of zero axes")
endmodule
